>>> src/rme_pkg.sv
package rme_pkg;

  // datapath widths
  localparam int OPW     = 17;  // negated q2.14 operand
  localparam int XW      = 36;  // cordic x/y lanes
  localparam int ZW      = 35;  // cordic angle accumulator, q2.30
  localparam int RW      = 63;  // square root remainder
  localparam int QW      = 31;  // square root result bits
  localparam int TAB_LEN = 24;

  localparam logic signed [ZW-1:0] ANG_PI      = 35'sd3373259426;
  localparam logic signed [ZW-1:0] Q13_PI      = 35'sd25736;
  localparam logic signed [ZW-1:0] Q13_HALF_PI = 35'sd12868;

  // pole codes
  localparam logic [1:0] POLE_NONE  = 2'd0;
  localparam logic [1:0] POLE_NORTH = 2'd1;
  localparam logic [1:0] POLE_SOUTH = 2'd2;

  typedef struct packed {
    logic [1:0]            pole;
    logic signed [OPW-1:0] xy;
    logic signed [OPW-1:0] xx;
    logic signed [OPW-1:0] zy;
    logic signed [OPW-1:0] zx;
    logic signed [15:0]    s;
  } side_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QW-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } cord_t;

  // atan(2^-i) in q2.30
  function automatic logic signed [ZW-1:0] atan_val(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = 35'sd843314857;
      1:  v = 35'sd497837829;
      2:  v = 35'sd263043837;
      3:  v = 35'sd133525159;
      4:  v = 35'sd67021687;
      5:  v = 35'sd33543516;
      6:  v = 35'sd16775851;
      7:  v = 35'sd8388437;
      8:  v = 35'sd4194283;
      9:  v = 35'sd2097149;
      10: v = 35'sd1048576;
      11: v = 35'sd524288;
      12: v = 35'sd262144;
      13: v = 35'sd131072;
      14: v = 35'sd65536;
      15: v = 35'sd32768;
      16: v = 35'sd16384;
      17: v = 35'sd8192;
      18: v = 35'sd4096;
      19: v = 35'sd2048;
      20: v = 35'sd1024;
      21: v = 35'sd512;
      22: v = 35'sd256;
      23: v = 35'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> src/rme_in_if.sv
interface rme_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] r00;
  logic [15:0] r02;
  logic [15:0] r10;
  logic [15:0] r11;
  logic [15:0] r12;
  logic [15:0] r20;
  logic [15:0] r22;

  modport source (output valid, r00, r02, r10, r11, r12, r20, r22, input ready);
  modport sink (input valid, r00, r02, r10, r11, r12, r20, r22, output ready);
endinterface

>>> src/rme_out_if.sv
interface rme_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] angle_x;
  logic [14:0] angle_y;
  logic [15:0] angle_z;
  logic [1:0]  pole_case;

  modport source (output valid, angle_x, angle_y, angle_z, pole_case, input ready);
  modport sink (input valid, angle_x, angle_y, angle_z, pole_case, output ready);
endinterface

>>> src/rotation_matrix_to_euler_core.sv
// Rotation matrix to Euler angles. Takes seven Q2.14 matrix entries per
// transaction and returns angle_x, angle_y, angle_z in Q3.13 radians with a
// pole code. One transaction is accepted every cycle unless a result waits on a
// stalled output. The pipeline runs through the input stage, 31 bit-cells of the
// square root for asin, operand setup, one CORDIC cell per stage and output rounding.
// The whole pipeline holds while a result waits on the output. Register 0
// at byte address 0 is pole_threshold (15 bits, reset 16351).
module rotation_matrix_to_euler_core #(
  parameter int CORDIC_STAGES = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rme_in_if.sink      in_s,
  rme_out_if.source   out_m,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NST = (CORDIC_STAGES < rme_pkg::TAB_LEN) ? CORDIC_STAGES
                                                          : rme_pkg::TAB_LEN;
  localparam int NV  = rme_pkg::QW + NST + 3;

  // configuration register
  logic [14:0] thr_q;
  assign pready = 1'b1;
  assign prdata = {17'b0, thr_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 15'd16351;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      thr_q <= pwdata[14:0];
    end
  end

  // pipeline advance: hold everything while the output transaction stalls
  logic [NV-1:0] vld_q;
  logic          en;
  assign en          = !vld_q[NV-1] || out_m.ready;
  assign in_s.ready  = en;
  assign out_m.valid = vld_q[NV-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NV-2:0], in_s.valid};
    end
  end

  // input stage: pole decision, operand selection, 1 - s*s
  logic signed [16:0]            m10, th;
  logic signed [31:0]            ss;
  logic signed [32:0]            dd;
  rme_pkg::side_t                side_d;
  rme_pkg::side_t                side_a_q;
  logic [28:0]                   d_a_q, d_d;

  always_comb begin
    m10 = 17'($signed(in_s.r10));
    th  = $signed({2'b0, thr_q});
    side_d.s  = $signed(in_s.r10);
    side_d.xy = -17'($signed(in_s.r12));
    side_d.xx = 17'($signed(in_s.r11));
    if (m10 > th) begin
      side_d.pole = rme_pkg::POLE_NORTH;
    end else if (m10 < -th) begin
      side_d.pole = rme_pkg::POLE_SOUTH;
    end else begin
      side_d.pole = rme_pkg::POLE_NONE;
    end
    if (side_d.pole != rme_pkg::POLE_NONE) begin
      // gimbal lock: z comes from the third column
      side_d.zy = 17'($signed(in_s.r02));
      side_d.zx = 17'($signed(in_s.r22));
    end else begin
      side_d.zy = -17'($signed(in_s.r20));
      side_d.zx = 17'($signed(in_s.r00));
    end
    ss = $signed(in_s.r10) * $signed(in_s.r10);
    dd = 33'sd268435456 - 33'(ss);
    d_d = dd[32] ? '0 : dd[28:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_a_q <= side_d;
      d_a_q    <= d_d;
    end
  end

  // square root chain, one result bit per cell, msb first
  rme_pkg::sqrt_t sq [0:rme_pkg::QW];
  rme_pkg::side_t sd [0:rme_pkg::QW];
  assign sq[0].rem  = rme_pkg::RW'(d_a_q) << 32;
  assign sq[0].root = '0;
  assign sd[0]      = side_a_q;

  for (genvar k = 0; k < rme_pkg::QW; k++) begin : g_sqrt
    rme_sqrt_cell #(.BIT(rme_pkg::QW - 1 - k)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .sq_i   (sq[k]),
      .side_i (sd[k]),
      .sq_o   (sq[k+1]),
      .side_o (sd[k+1])
    );
  end

  // operand setup: scale to q30, fold the left half plane onto the right
  function automatic rme_pkg::cord_t prep(input logic signed [rme_pkg::XW-1:0] y,
                                          input logic signed [rme_pkg::XW-1:0] x);
    rme_pkg::cord_t c;
    c.zero = (x == '0) && (y == '0);
    c.x    = x;
    c.y    = y;
    c.z    = '0;
    if (x[rme_pkg::XW-1]) begin
      c.z = y[rme_pkg::XW-1] ? -rme_pkg::ANG_PI : rme_pkg::ANG_PI;
      c.x = -x;
      c.y = -y;
    end
    return c;
  endfunction

  rme_pkg::cord_t cx [0:NST];
  rme_pkg::cord_t cy [0:NST];
  rme_pkg::cord_t cz [0:NST];
  logic [1:0]     pole_q [0:NST];
  rme_pkg::side_t sf;
  assign sf = sd[rme_pkg::QW];

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx[0]     <= prep(rme_pkg::XW'(sf.xy) <<< 16, rme_pkg::XW'(sf.xx) <<< 16);
      cy[0]     <= prep(rme_pkg::XW'(sf.s) <<< 16,
                        $signed(rme_pkg::XW'(sq[rme_pkg::QW].root)));
      cz[0]     <= prep(rme_pkg::XW'(sf.zy) <<< 16, rme_pkg::XW'(sf.zx) <<< 16);
      pole_q[0] <= sf.pole;
    end
  end

  // three cordic lanes side by side
  for (genvar i = 0; i < NST; i++) begin : g_cordic
    rme_cordic_cell #(.STAGE(i)) u_x (.clk_i(clk_i), .en_i(en), .c_i(cx[i]), .c_o(cx[i+1]));
    rme_cordic_cell #(.STAGE(i)) u_y (.clk_i(clk_i), .en_i(en), .c_i(cy[i]), .c_o(cy[i+1]));
    rme_cordic_cell #(.STAGE(i)) u_z (.clk_i(clk_i), .en_i(en), .c_i(cz[i]), .c_o(cz[i+1]));
    always_ff @(posedge clk_i) begin
      if (en) pole_q[i+1] <= pole_q[i];
    end
  end

  // q2.30 to q3.13, round half up, saturate; zero when both operands were zero
  function automatic logic [15:0] rnd(input rme_pkg::cord_t c,
                                      input logic signed [rme_pkg::ZW-1:0] lim);
    logic signed [rme_pkg::ZW-1:0] t;
    t = (c.z + rme_pkg::ZW'(65536)) >>> 17;
    if (t > lim) t = lim;
    if (t < -lim) t = -lim;
    if (c.zero) t = '0;
    return t[15:0];
  endfunction

  logic [15:0] ax_q, az_q, ay_w;
  logic [14:0] ay_q;
  logic [1:0]  pc_q;
  logic [1:0]  pl;
  assign pl   = pole_q[NST];
  assign ay_w = rnd(cy[NST], rme_pkg::Q13_HALF_PI);

  always_ff @(posedge clk_i) begin
    if (en) begin
      pc_q <= pl;
      az_q <= rnd(cz[NST], rme_pkg::Q13_PI);
      case (pl)
        rme_pkg::POLE_NORTH: begin
          ax_q <= '0;
          ay_q <= rme_pkg::Q13_HALF_PI[14:0];
        end
        rme_pkg::POLE_SOUTH: begin
          ax_q <= '0;
          ay_q <= 15'(-rme_pkg::Q13_HALF_PI);
        end
        default: begin
          ax_q <= rnd(cx[NST], rme_pkg::Q13_PI);
          ay_q <= ay_w[14:0];
        end
      endcase
    end
  end

  assign out_m.angle_x   = ax_q;
  assign out_m.angle_y   = ay_q;
  assign out_m.angle_z   = az_q;
  assign out_m.pole_case = pc_q;

endmodule

>>> src/rme_sqrt_cell.sv
module rme_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  rme_pkg::sqrt_t sq_i,
  input  rme_pkg::side_t side_i,
  output rme_pkg::sqrt_t sq_o,
  output rme_pkg::side_t side_o
);

  rme_pkg::sqrt_t       sq_d;
  logic [rme_pkg::RW-1:0] test;

  // one result bit: try (root + 2^bit)^2 against the remainder
  always_comb begin
    test = (rme_pkg::RW'(sq_i.root) << (BIT + 1)) + (rme_pkg::RW'(1) << (2 * BIT));
    sq_d = sq_i;
    if (sq_i.rem >= test) begin
      sq_d.rem  = sq_i.rem - test;
      sq_d.root = sq_i.root | (rme_pkg::QW'(1) << BIT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_o   <= sq_d;
      side_o <= side_i;
    end
  end

endmodule

>>> src/rme_cordic_cell.sv
module rme_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  rme_pkg::cord_t c_i,
  output rme_pkg::cord_t c_o
);

  logic signed [rme_pkg::XW-1:0] xv, yv, dx, dy;
  rme_pkg::cord_t c_d;

  // one micro-rotation toward the x axis
  always_comb begin
    xv  = c_i.x;
    yv  = c_i.y;
    dx  = yv >>> STAGE;
    dy  = xv >>> STAGE;
    c_d = c_i;
    if (!yv[rme_pkg::XW-1]) begin
      c_d.x = xv + dx;
      c_d.y = yv - dy;
      c_d.z = c_i.z + rme_pkg::atan_val(STAGE);
    end else begin
      c_d.x = xv - dx;
      c_d.y = yv + dy;
      c_d.z = c_i.z - rme_pkg::atan_val(STAGE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) c_o <= c_d;
  end

endmodule

>>> dv/rotation_matrix_to_euler_core_test.sv
`timescale 1ns / 100ps

module rotation_matrix_to_euler_core_test;

  localparam int STAGES = 14;
  // input stage, 31 square root cells, setup, cordic cells, rounding
  localparam int LATENCY = STAGES + 34;
  localparam int THR_RESET = 16351;
  localparam logic [2:0] THR_ADDR = 3'd0;

  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r02;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] r22;
  } matrix_t;

  typedef struct packed {
    logic [15:0] ax;
    logic [14:0] ay;
    logic [15:0] az;
    logic [1:0]  pole;
  } euler_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rme_in_if  mat_if ();
  rme_out_if ang_if ();

  rotation_matrix_to_euler_core #(.CORDIC_STAGES(STAGES)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_s    (mat_if.sink),
    .out_m   (ang_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor copy of the register
  logic [14:0] pole_thr;
  euler_t      angles_due[$];
  int          mismatches;
  int          angles_seen;
  int          poles_seen[3];
  int          sent_count;
  bit          calm;        // no random idling on either side while set
  bit          hold_req;
  int          hold_left;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  // vectoring cordic on q30 operands, angle in q2.30
  function automatic longint arc_tan(longint y, longint x);
    longint z;
    longint dx;
    longint dy;
    int     n;
    z = 0;
    n = (STAGES < rme_pkg::TAB_LEN) ? STAGES : rme_pkg::TAB_LEN;
    if (x == 0 && y == 0) return 0;
    // left half plane: fold over and start from +-pi
    if (x < 0) begin
      z = (y < 0) ? -longint'(rme_pkg::ANG_PI) : longint'(rme_pkg::ANG_PI);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < n; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += longint'(rme_pkg::atan_val(i));
      end else begin
        x -= dx;
        y += dy;
        z -= longint'(rme_pkg::atan_val(i));
      end
    end
    return z;
  endfunction

  // q2.30 to q3.13, round half up, then saturate
  function automatic longint to_q13(longint a, longint lim);
    longint r;
    r = (a + 65536) >>> 17;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint angle_of(longint y, longint x);
    return to_q13(arc_tan(y * 65536, x * 65536), longint'(rme_pkg::Q13_PI));
  endfunction

  // asin(s) = atan2(s, sqrt(1 - s*s)), cosine clamped at zero
  function automatic longint pitch_of(longint s);
    longint          d;
    longint unsigned c;
    d = (longint'(1) << 28) - s * s;
    if (d < 0) d = 0;
    c = floor_root(longint'(d) << 32);
    return to_q13(arc_tan(s * 65536, longint'(c)), longint'(rme_pkg::Q13_HALF_PI));
  endfunction

  function automatic euler_t euler_of(matrix_t m);
    euler_t e;
    longint thr;
    longint s;
    longint ax, ay, az;
    thr = longint'(pole_thr);
    s   = longint'(m.r10);
    if (s > thr) begin
      ax = 0;
      ay = longint'(rme_pkg::Q13_HALF_PI);
      az = angle_of(m.r02, m.r22);
      e.pole = rme_pkg::POLE_NORTH;
    end else if (s < -thr) begin
      ax = 0;
      ay = -longint'(rme_pkg::Q13_HALF_PI);
      az = angle_of(m.r02, m.r22);
      e.pole = rme_pkg::POLE_SOUTH;
    end else begin
      ax = angle_of(-longint'(m.r12), m.r11);
      ay = pitch_of(s);
      az = angle_of(-longint'(m.r20), m.r00);
      e.pole = rme_pkg::POLE_NONE;
    end
    e.ax = ax[15:0];
    e.ay = ay[14:0];
    e.az = az[15:0];
    return e;
  endfunction

  // ------------------------------------------------------------ result side

  // receiver stalls at random, or for a long stretch on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_if.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (hold_req) begin
        hold_left = 300;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        ang_if.ready <= 1'b0;
      end else begin
        ang_if.ready <= calm || ($urandom_range(99) >= 29);
      end
    end
  end

  // compare each result transaction against the oldest prediction
  always @(posedge clk_i) begin
    euler_t got;
    euler_t want;
    if (rst_ni && ang_if.valid && ang_if.ready) begin
      got = '{ax: ang_if.angle_x, ay: ang_if.angle_y, az: ang_if.angle_z,
              pole: ang_if.pole_case};
      if (angles_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t unexpected result x=%0d y=%0d z=%0d pole=%0d", $realtime,
                   $signed(got.ax), $signed(got.ay), $signed(got.az), got.pole);
      end else begin
        want = angles_due.pop_front();
        angles_seen++;
        if (want.pole <= rme_pkg::POLE_SOUTH) poles_seen[want.pole]++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t mismatch: expected x/y/z/pole %0d %0d %0d %0d, got %0d %0d %0d %0d",
                     $realtime, $signed(want.ax), $signed(want.ay), $signed(want.az),
                     want.pole, $signed(got.ax), $signed(got.ay), $signed(got.az), got.pole);
        end
      end
    end
  end

  // ------------------------------------------------------------- input side

  task automatic send_matrix(matrix_t m);
    while (!calm && $urandom_range(99) < 29) begin
      mat_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    mat_if.valid <= 1'b1;
    mat_if.r00   <= m.r00;
    mat_if.r02   <= m.r02;
    mat_if.r10   <= m.r10;
    mat_if.r11   <= m.r11;
    mat_if.r12   <= m.r12;
    mat_if.r20   <= m.r20;
    mat_if.r22   <= m.r22;
    do @(posedge clk_i); while (!mat_if.ready);
    // transaction taken at this edge: predict with the current threshold
    angles_due = {angles_due, euler_of(m)};
    sent_count++;
  endtask

  task automatic drain_results();
    mat_if.valid <= 1'b0;
    while (angles_due.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [14:0] value);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= THR_ADDR;
    pwdata  <= {17'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pole_thr = value;
    // read back through prdata
    @(posedge clk_i);
    if (prdata[14:0] !== value) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t threshold readback: expected %0d, got %0d", $realtime,
                 value, prdata[14:0]);
    end
  endtask

  function automatic logic signed [15:0] entry_any(bit wide);
    if (wide) return 16'($urandom);
    return 16'($urandom_range(32768) - 16384);
  endfunction

  function automatic matrix_t random_matrix();
    matrix_t m;
    int      pick;
    bit      wide;
    wide  = ($urandom_range(99) < 10);
    m.r00 = entry_any(wide);
    m.r02 = entry_any(wide);
    m.r11 = entry_any(wide);
    m.r12 = entry_any(wide);
    m.r20 = entry_any(wide);
    m.r22 = entry_any(wide);
    pick  = $urandom_range(9);
    // steer r10 toward the pole boundaries a good share of the time
    if (pick < 3)
      m.r10 = 16'(int'(pole_thr) + $urandom_range(6) - 3);
    else if (pick < 5)
      m.r10 = 16'(-int'(pole_thr) + $urandom_range(6) - 3);
    else
      m.r10 = entry_any(wide);
    // sometimes zero an operand pair or one side of it
    if ($urandom_range(19) == 0) begin
      m.r11 = '0;
      m.r12 = '0;
    end
    if ($urandom_range(19) == 0) m.r20 = '0;
    if ($urandom_range(19) == 0) m.r02 = '0;
    return m;
  endfunction

  // ----------------------------------------------------------------- tests

  task automatic test_directed();
    matrix_t d[$] = '{
      // identity, all zero (both atan2 operands zero)
      '{16384, 0, 0, 16384, 0, 0, 16384},
      '{0, 0, 0, 0, 0, 0, 0},
      // negative x operand with zero y gives +pi
      '{-16384, 0, 0, -16384, 0, 0, -16384},
      // negative x with negative y operand starts from -pi
      '{-16384, 5, 100, -16384, 300, 300, 16384},
      '{-1, 0, 0, -1, 1, 1, 0},
      // pole boundary: at the threshold, one above, one below
      '{8000, 1000, 16'(THR_RESET), 100, 50, 20, 900},
      '{8000, 1000, 16'(THR_RESET + 1), 100, 50, 20, 900},
      '{8000, -1000, -16'(THR_RESET + 1), 100, 50, 20, -900},
      '{8000, -1000, -16'(THR_RESET), 100, 50, 20, -900},
      // full scale and extreme entries
      '{16384, 16384, 16384, 16384, 16384, 16384, 16384},
      '{-16384, -16384, -16384, -16384, -16384, -16384, -16384},
      '{32767, 32767, 32767, 32767, 32767, 32767, 32767},
      '{-32768, -32768, -32768, -32768, -32768, -32768, -32768},
      // r10 near plus and minus full scale, beyond the pole threshold
      '{100, 0, 16383, 16384, 0, 0, 16384},
      '{100, 0, -16383, 16384, 0, 0, 16384},
      // x operand zero, y of either sign
      '{0, 16384, 0, 0, -16384, 16384, 0},
      '{0, -16384, 0, 0, 16384, -16384, 0},
      '{11585, 0, 11585, 11585, -11585, -11585, 11585}
    };
    foreach (d[i]) send_matrix(d[i]);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      // a calm stretch in the middle of each random run
      calm = (i >= count / 3) && (i < count / 3 + 60);
      send_matrix(random_matrix());
    end
    calm = 1'b0;
  endtask

  // receiver stops for a long stretch while matrices keep coming
  task automatic test_backpressure();
    hold_req = 1'b1;
    calm     = 1'b1;
    for (int i = 0; i < 150; i++) send_matrix(random_matrix());
    calm = 1'b0;
  endtask

  initial begin
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    mat_if.valid = 1'b0;
    mat_if.r00   = '0;
    mat_if.r02   = '0;
    mat_if.r10   = '0;
    mat_if.r11   = '0;
    mat_if.r12   = '0;
    mat_if.r20   = '0;
    mat_if.r22   = '0;
    pole_thr     = 15'(THR_RESET);
    mismatches   = 0;
    angles_seen  = 0;
    sent_count   = 0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    poles_seen   = '{0, 0, 0};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(250);
    write_threshold(15'd0);
    test_directed();
    test_random(150);
    write_threshold(15'd16384);
    test_random(150);
    write_threshold(15'd32767);
    test_random(100);
    write_threshold(15'($urandom_range(16384)));
    test_random(150);
    test_backpressure();
    write_threshold(15'(THR_RESET));
    test_random(150);
    drain_results();

    $display("tb: %0d matrices sent, %0d checked (%0d regular, %0d north, %0d south)",
             sent_count, angles_seen, poles_seen[0], poles_seen[1], poles_seen[2]);
    $display("tb: thresholds 0, 16384, 32767, random and reset value, with a long output stall");
    if (mismatches == 0 && angles_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches, %0d results missing", mismatches, angles_due.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule
